[design/pdf_pkg.sv]
// ----------------------------------------------------------------------------
// pdf_pkg
// shared constants, coefficient rom and control types of the polyphase
// decimating fir
// ----------------------------------------------------------------------------
package pdf_pkg;

  localparam int PHASES  = 4;
  localparam int TAPS    = 11;
  localparam int DATA_W  = 16;
  localparam int PROD_W  = 2 * DATA_W;
  localparam int ACC_W   = 32;
  localparam int PROD_SH = 8;
  localparam int OUT_SH  = 7;
  localparam int NUM_ENT = PHASES * TAPS;
  localparam int ADDR_W  = (NUM_ENT > 1) ? $clog2(NUM_ENT) : 1;
  localparam int ROW_W   = (PHASES > 1) ? $clog2(PHASES) : 1;
  localparam int TAP_W   = (TAPS > 1) ? $clog2(TAPS) : 1;

  localparam logic signed [DATA_W-1:0] COEF_ROM [PHASES][TAPS] = '{
    '{-16'sd15, -16'sd119, 16'sd337, -16'sd219, -16'sd1029, 16'sd6888,
      16'sd2247, 16'sd484, -16'sd612, 16'sd223, 16'sd9},
    '{16'sd72, -16'sd172, 16'sd94, 16'sd612, -16'sd2127, 16'sd10199,
      -16'sd1205, 16'sd1092, -16'sd378, -16'sd34, 16'sd79},
    '{16'sd79, -16'sd34, -16'sd378, 16'sd1092, -16'sd1205, 16'sd10199,
      -16'sd2127, 16'sd612, 16'sd94, -16'sd172, 16'sd72},
    '{16'sd9, 16'sd223, -16'sd612, 16'sd484, 16'sd2247, 16'sd6888,
      -16'sd1029, -16'sd219, 16'sd337, -16'sd119, -16'sd15}
  };

  typedef enum logic [2:0] {
    S_IDLE,
    S_ISSUE,
    S_DRAIN1,
    S_DRAIN2,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic             load;
    logic             issue;
    logic [TAP_W-1:0] tap;
    logic             finish;
  } pdf_cmd_t;

  typedef struct packed {
    logic last_phase;
    logic out_free;
  } pdf_sts_t;

endpackage

[design/polyphase_decimating_fir.sv]
// ----------------------------------------------------------------------------
// polyphase_decimating_fir
// 44-tap low-pass fir decimating by 4, split into 4 phases of 11 taps,
// one shared multiply-accumulate stepping over the taps of a phase
// ----------------------------------------------------------------------------
//  channel  ports                              direction
//  in       in_valid in_ready in_sample in_last   sink
//  out      out_valid out_ready out_sample out_last source
//
//  each sample runs, before the next is accepted, through the accept cycle,
//  a step for each tap through the single delay line ram port pair and the
//  multiplier, the drain states S_DRAIN1 and S_DRAIN2, and the commit cycle
//  every fourth sample loads the output register; a new sample is taken
//  while that result still waits
//  the commit cycle of a fourth sample holds while the output register is
//  still full
//  synchronous active-low reset clears counters, total and delay line
//  valid bits; the ram itself is not cleared
module polyphase_decimating_fir (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [pdf_pkg::DATA_W-1:0] in_sample,
  input  logic                              in_last,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [pdf_pkg::DATA_W-1:0] out_sample,
  output logic                              out_last
);
  import pdf_pkg::*;

  pdf_cmd_t cmd;
  pdf_sts_t sts;

  pdf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pdf_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_sample  (in_sample),
    .in_last    (in_last),
    .cmd        (cmd),
    .sts        (sts),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_sample (out_sample),
    .out_last   (out_last)
  );

endmodule

[design/pdf_ram.sv]
// ----------------------------------------------------------------------------
// pdf_ram
// generic simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module pdf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 44
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[design/pdf_ctrl.sv]
// ----------------------------------------------------------------------------
// pdf_ctrl
// sequencer of the polyphase decimating fir: accepts a sample, steps the
// tap counter, waits for the mac pipeline and commits the phase
// ----------------------------------------------------------------------------
module pdf_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  pdf_pkg::pdf_sts_t  sts,
  output pdf_pkg::pdf_cmd_t  cmd
);
  import pdf_pkg::*;

  state_t           state_r, state_nxt;
  logic [TAP_W-1:0] tap_r, tap_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      tap_r   <= '0;
    end else begin
      state_r <= state_nxt;
      tap_r   <= tap_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    tap_nxt   = tap_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_ISSUE;
          tap_nxt   = TAP_W'(TAPS - 1);
        end
      end
      S_ISSUE: begin
        if (tap_r == '0) begin
          state_nxt = S_DRAIN1;
        end else begin
          tap_nxt = tap_r - TAP_W'(1);
        end
      end
      S_DRAIN1: state_nxt = S_DRAIN2;
      S_DRAIN2: state_nxt = S_FINISH;
      S_FINISH: begin
        if (!sts.last_phase || sts.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready   = 1'b0;
    cmd.load   = 1'b0;
    cmd.issue  = 1'b0;
    cmd.finish = 1'b0;
    cmd.tap    = tap_r;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_ISSUE:  cmd.issue = 1'b1;
      S_DRAIN1: ;
      S_DRAIN2: ;
      S_FINISH: cmd.finish = !sts.last_phase || sts.out_free;
      default: ;
    endcase
  end

  a_load_starts_issue: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> state_r == S_ISSUE && tap_r == TAP_W'(TAPS - 1))
    else $error("load did not start tap sequence");

  a_finish_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FINISH && sts.last_phase && !sts.out_free |=> state_r == S_FINISH)
    else $error("finish left while output slot busy");

endmodule

[design/pdf_dp.sv]
// ----------------------------------------------------------------------------
// pdf_dp
// datapath: delay line ram with valid bits, shared multiplier, running
// total, phase counter and output register
// ----------------------------------------------------------------------------
module pdf_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic signed [pdf_pkg::DATA_W-1:0]   in_sample,
  input  logic                                in_last,
  input  pdf_pkg::pdf_cmd_t                   cmd,
  output pdf_pkg::pdf_sts_t                   sts,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [pdf_pkg::DATA_W-1:0]   out_sample,
  output logic                                out_last
);
  import pdf_pkg::*;

  logic signed [DATA_W-1:0] sample_r;
  logic                     last_r;
  logic [ROW_W-1:0]         cnt_r;
  logic [ACC_W-1:0]         total_r;
  logic [NUM_ENT-1:0]       vbit_r;
  logic                     s1_v_r;
  logic [TAP_W-1:0]         s1_tap_r;
  logic                     s1_ok_r;
  logic                     s2_v_r;
  logic signed [PROD_W-1:0] prod_r;
  logic                     out_valid_r;
  logic signed [DATA_W-1:0] out_sample_r;
  logic                     out_last_r;

  logic [ROW_W-1:0]         row;
  logic [ADDR_W-1:0]        base;
  logic [ADDR_W-1:0]        rd_addr;
  logic [ADDR_W-1:0]        wr_addr;
  logic                     rd_en;
  logic [DATA_W-1:0]        ram_rdata;
  logic signed [DATA_W-1:0] tap_data;
  logic signed [DATA_W-1:0] coef;
  logic signed [PROD_W-1:0] prod;
  logic                     out_free;

  assign row     = ROW_W'(PHASES - 1) - cnt_r;
  assign base    = ADDR_W'(ADDR_W'(row) * ADDR_W'(TAPS));
  assign rd_en   = cmd.issue && (cmd.tap != '0);
  assign rd_addr = base + ADDR_W'(cmd.tap) - ADDR_W'(1);
  assign wr_addr = base + ADDR_W'(s1_tap_r);

  pdf_ram #(
    .WIDTH (DATA_W),
    .DEPTH (NUM_ENT)
  ) u_ram (
    .clk   (clk),
    .we    (s1_v_r),
    .waddr (wr_addr),
    .wdata (tap_data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  // tap 0 takes the new sample, the rest shift from the previous tap, or take zero while it is still invalid
  always_comb begin
    if (s1_tap_r == '0) begin
      tap_data = sample_r;
    end else if (s1_ok_r) begin
      tap_data = ram_rdata;
    end else begin
      tap_data = '0;
    end
  end

  assign coef     = COEF_ROM[row][s1_tap_r];
  assign prod     = tap_data * coef;
  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sample_r <= in_sample;
      last_r   <= in_last;
    end
    s1_tap_r <= cmd.tap;
    s1_ok_r  <= vbit_r[rd_addr];
    prod_r   <= prod;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      total_r     <= '0;
      vbit_r      <= '0;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_v_r <= cmd.issue;
      s2_v_r <= s1_v_r;
      if (s1_v_r) begin
        vbit_r[wr_addr] <= 1'b1;
      end
      // truncate q2.30 product to q10.22, wrap at 32 bits
      if (s2_v_r) begin
        total_r <= total_r + ACC_W'({{PROD_SH{prod_r[PROD_W-1]}}, prod_r[PROD_W-1:PROD_SH]});
      end
      if (cmd.finish && sts.last_phase) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.finish) begin
        if (sts.last_phase) begin
          cnt_r   <= '0;
          total_r <= '0;
        end else begin
          cnt_r <= cnt_r + ROW_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish && sts.last_phase) begin
      out_sample_r <= total_r[OUT_SH +: DATA_W];
      out_last_r   <= last_r;
    end
  end

  assign sts.last_phase = (cnt_r == ROW_W'(PHASES - 1));
  assign sts.out_free   = out_free;
  assign out_valid      = out_valid_r;
  assign out_sample     = out_sample_r;
  assign out_last       = out_last_r;

  a_no_port_clash: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && rd_en |-> wr_addr != rd_addr)
    else $error("delay line read and write collide");

  a_group_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish && sts.last_phase |=> total_r == '0 && cnt_r == '0 && out_valid_r)
    else $error("group end did not clear total and counter");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= ROW_W'(PHASES - 1))
    else $error("phase counter out of range");

endmodule
